// ===== design/dvfs_state_governor_macros.svh =====
// Assertion helpers for the governor. Both sample on clk_i and are quiet in reset.
`ifndef DVFS_STATE_GOVERNOR_MACROS_SVH
`define DVFS_STATE_GOVERNOR_MACROS_SVH

`ifndef SYNTHESIS
`define DSG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define DSG_ASSERT_NEVER(lbl, cond, msg) \
  `DSG_ASSERT(lbl, !(cond), msg)
`else
`define DSG_ASSERT(lbl, prop, msg)
`define DSG_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

// ===== design/dsg_pkg.sv =====
package dsg_pkg;

  localparam int unsigned CMD_W     = 3;
  localparam int unsigned TIME_W    = 64;
  localparam int unsigned TPUT_W    = 32;
  localparam int unsigned CONF_W    = 9;
  localparam int unsigned LEVEL_W   = 2;
  localparam int unsigned HYST_W    = 8;
  localparam int unsigned LOCK_W    = 24;
  localparam int unsigned FRAME_W   = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_W     = 32;
  // 255 frames of 16667 us fit in 23 bits
  localparam int unsigned GUARD_W   = 23;

  localparam logic [14:0] FRAME_PERIOD_US = 15'd16667;

  localparam logic [TPUT_W-1:0] HIGH_THR_RST  = 32'd40000;
  localparam logic [TPUT_W-1:0] MID_THR_RST   = 32'd20000;
  localparam logic [CONF_W-1:0] CONF_LOW_RST  = 9'd90;
  localparam logic [CONF_W-1:0] CONF_HIGH_RST = 9'd210;
  localparam logic [HYST_W-1:0] HYST_RST      = 8'd3;
  localparam logic [LOCK_W-1:0] LOCK_US_RST   = 24'd500;
  localparam logic [GUARD_W-1:0] GUARD_RST    = 23'd50001;

  typedef enum logic [CMD_W-1:0] {
    CMD_TIMED   = 3'd0,
    CMD_CONF    = 3'd1,
    CMD_STALL   = 3'd2,
    CMD_FORCE   = 3'd3,
    CMD_RELEASE = 3'd4,
    CMD_FRAME   = 3'd5
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HIGH_THR  = 3'd0,
    CFG_MID_THR   = 3'd1,
    CFG_CONF_LOW  = 3'd2,
    CFG_CONF_HIGH = 3'd3,
    CFG_HYST      = 3'd4,
    CFG_LOCK_US   = 3'd5
  } cfg_idx_e;

  localparam logic [LEVEL_W-1:0] LVL_MAX = 2'd0;
  localparam logic [LEVEL_W-1:0] LVL_BAL = 2'd1;
  localparam logic [LEVEL_W-1:0] LVL_EFF = 2'd2;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               in_transition;
    logic [LEVEL_W-1:0] pending_level;
    logic               locked;
    logic               changed;
  } res_t;

  function automatic logic [LEVEL_W-1:0] level_for(input logic [TPUT_W-1:0] mbps,
                                                   input logic [TPUT_W-1:0] high_thr,
                                                   input logic [TPUT_W-1:0] mid_thr);
    logic [LEVEL_W-1:0] lvl;
    if (mbps > high_thr) lvl = LVL_MAX;
    else if (mbps > mid_thr) lvl = LVL_BAL;
    else lvl = LVL_EFF;
    return lvl;
  endfunction

endpackage

// ===== design/dsg_in_if.sv =====
interface dsg_in_if;
  logic                         valid;
  logic                         ready;
  logic [dsg_pkg::CMD_W-1:0]    command;
  logic [dsg_pkg::TIME_W-1:0]   time_us;
  logic [dsg_pkg::TPUT_W-1:0]   throughput;
  logic [dsg_pkg::CONF_W-1:0]   confidence_q8;
  logic [dsg_pkg::LEVEL_W-1:0]  target_level;

  modport source (output valid, command, time_us, throughput, confidence_q8, target_level,
                  input ready);
  modport sink (input valid, command, time_us, throughput, confidence_q8, target_level,
                output ready);
endinterface

// ===== design/dsg_out_if.sv =====
interface dsg_out_if;
  logic                         valid;
  logic                         ready;
  logic [dsg_pkg::LEVEL_W-1:0]  level;
  logic                         in_transition;
  logic [dsg_pkg::LEVEL_W-1:0]  pending_level;
  logic                         locked;
  logic                         changed;

  modport source (output valid, level, in_transition, pending_level, locked, changed,
                  input ready);
  modport sink (input valid, level, in_transition, pending_level, locked, changed,
                output ready);
endinterface

// ===== design/dvfs_state_governor.sv =====
// Performance level governor with hysteresis.
// Channels: in_if carries one command word (timed update, confidence update, stall,
// force, release, frame tick) with its time, throughput, confidence and forced level;
// out_if returns one status word per command: level, transition flag, pending level,
// lock flag and whether this command changed the level.
// Configuration: cfg_we_i writes cfg_data_i to register cfg_idx_i; write
// only while no words are in flight.
// Status: each accepted command's word goes to the result register, or to the skid
// register while a result waits. Throughput: one command per cycle if in_if.ready
// is high, via one pass of compares and 64-bit adds into state and result registers.
// The hysteresis time guard is recomputed when its register is written, so the
// multiply stays off the command path.
// Stalls: a two-entry output buffer (result register plus skid register) keeps
// accepting one more command while a result waits; in_if.ready falls only while both
// hold words.
// Reset: level maximum, no window open, unlocked, counters and times zero, registers
// at their defaults, output buffer empty.
`include "dvfs_state_governor_macros.svh"

module dvfs_state_governor (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [dsg_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [dsg_pkg::CFG_W-1:0]       cfg_data_i,
  dsg_in_if.sink                          in_if,
  dsg_out_if.source                       out_if
);
  import dsg_pkg::*;

  // configuration
  logic [TPUT_W-1:0]  high_thr_q, mid_thr_q;
  logic [CONF_W-1:0]  conf_low_q, conf_high_q;
  logic [HYST_W-1:0]  hyst_q;
  logic [LOCK_W-1:0]  lock_us_q;
  logic [GUARD_W-1:0] guard_q;

  // governor state
  logic               trans_q, trans_d;
  logic [LEVEL_W-1:0] cur_q, cur_d;
  logic [LEVEL_W-1:0] next_q, next_d;
  logic               plock_q, plock_d;
  logic [TIME_W-1:0]  win_end_q, win_end_d;
  logic [TIME_W-1:0]  last_sw_q, last_sw_d;
  logic [FRAME_W-1:0] frames_q, frames_d;

  // output buffer
  logic main_v_q, skid_v_q;
  res_t main_q, skid_q, res_d;

  logic accept, pop;
  logic [LEVEL_W-1:0] want_tp, want_conf;
  logic enough_frames, window_done, guard_ok;
  logic [TIME_W-1:0] since_sw;
  logic acc_stall, acc_conf_locked;

  assign in_if.ready = !skid_v_q;
  assign accept      = in_if.valid && in_if.ready;
  assign pop         = main_v_q && out_if.ready;

  assign want_tp       = level_for(in_if.throughput, high_thr_q, mid_thr_q);
  assign want_conf     = (in_if.confidence_q8 >= conf_high_q) ? want_tp : LVL_BAL;
  assign enough_frames = frames_q > {{(FRAME_W-HYST_W){1'b0}}, hyst_q};
  assign window_done   = in_if.time_us >= win_end_q;
  assign since_sw      = in_if.time_us - last_sw_q;
  assign guard_ok      = since_sw > {{(TIME_W-GUARD_W){1'b0}}, guard_q};

  always_comb begin
    trans_d   = trans_q;
    cur_d     = cur_q;
    next_d    = next_q;
    plock_d   = plock_q;
    win_end_d = win_end_q;
    last_sw_d = last_sw_q;
    frames_d  = frames_q;
    unique case (in_if.command)
      CMD_TIMED: begin
        if (trans_q) begin
          if (window_done) begin
            cur_d     = next_q;
            trans_d   = 1'b0;
            last_sw_d = win_end_q;
            frames_d  = '0;
          end
        end else if (!plock_q) begin
          if (want_tp != cur_q && enough_frames && guard_ok) begin
            trans_d   = 1'b1;
            win_end_d = in_if.time_us + {{(TIME_W-LOCK_W){1'b0}}, lock_us_q};
            next_d    = want_tp;
          end
        end
      end
      CMD_CONF: begin
        if (in_if.confidence_q8 >= conf_low_q && !plock_q
            && want_conf != cur_q && enough_frames) begin
          cur_d    = want_conf;
          frames_d = '0;
        end
      end
      CMD_STALL: begin
        trans_d  = 1'b0;
        cur_d    = LVL_MAX;
        frames_d = '0;
      end
      CMD_FORCE: begin
        plock_d  = 1'b1;
        // a forced level of 3 saturates to efficient
        cur_d    = (in_if.target_level > LVL_EFF) ? LVL_EFF : in_if.target_level;
        frames_d = '0;
      end
      CMD_RELEASE: plock_d = 1'b0;
      CMD_FRAME: begin
        if (frames_q != {FRAME_W{1'b1}}) frames_d = frames_q + FRAME_W'(1);
      end
      default: ;
    endcase
  end

  always_comb begin
    res_d.level         = cur_d;
    res_d.in_transition = trans_d;
    res_d.pending_level = next_d;
    res_d.locked        = plock_d;
    res_d.changed       = cur_d != cur_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      high_thr_q  <= HIGH_THR_RST;
      mid_thr_q   <= MID_THR_RST;
      conf_low_q  <= CONF_LOW_RST;
      conf_high_q <= CONF_HIGH_RST;
      hyst_q      <= HYST_RST;
      lock_us_q   <= LOCK_US_RST;
      guard_q     <= GUARD_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_HIGH_THR:  high_thr_q  <= cfg_data_i;
        CFG_MID_THR:   mid_thr_q   <= cfg_data_i;
        CFG_CONF_LOW:  conf_low_q  <= cfg_data_i[CONF_W-1:0];
        CFG_CONF_HIGH: conf_high_q <= cfg_data_i[CONF_W-1:0];
        CFG_HYST: begin
          hyst_q  <= cfg_data_i[HYST_W-1:0];
          guard_q <= GUARD_W'(cfg_data_i[HYST_W-1:0]) * GUARD_W'(FRAME_PERIOD_US);
        end
        CFG_LOCK_US:   lock_us_q   <= cfg_data_i[LOCK_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trans_q   <= 1'b0;
      cur_q     <= LVL_MAX;
      next_q    <= LVL_MAX;
      plock_q   <= 1'b0;
      win_end_q <= '0;
      last_sw_q <= '0;
      frames_q  <= '0;
    end else if (accept) begin
      trans_q   <= trans_d;
      cur_q     <= cur_d;
      next_q    <= next_d;
      plock_q   <= plock_d;
      win_end_q <= win_end_d;
      last_sw_q <= last_sw_d;
      frames_q  <= frames_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (pop) begin
      if (skid_v_q) begin
        skid_v_q <= 1'b0;
      end else if (!accept) begin
        main_v_q <= 1'b0;
      end
    end else if (accept) begin
      if (main_v_q) skid_v_q <= 1'b1;
      else main_v_q <= 1'b1;
    end
  end

  // payload of the buffer, no reset
  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (skid_v_q) main_q <= skid_q;
      else if (accept) main_q <= res_d;
    end else if (accept) begin
      if (main_v_q) skid_q <= res_d;
      else main_q <= res_d;
    end
  end

  assign out_if.valid         = main_v_q;
  assign out_if.level         = main_q.level;
  assign out_if.in_transition = main_q.in_transition;
  assign out_if.pending_level = main_q.pending_level;
  assign out_if.locked        = main_q.locked;
  assign out_if.changed       = main_q.changed;

  assign acc_stall       = accept && in_if.command == CMD_STALL;
  assign acc_conf_locked = accept && plock_q && in_if.command == CMD_CONF;

  `DSG_ASSERT_NEVER(a_skid_without_main, skid_v_q && !main_v_q, "skid word without result word")
  `DSG_ASSERT_NEVER(a_level_range, cur_q == 2'd3, "current level out of range")
  `DSG_ASSERT(a_stall_closes, acc_stall |=> !trans_q && cur_q == LVL_MAX, "stall left window")
  `DSG_ASSERT(a_lock_holds, acc_conf_locked |=> $stable(cur_q), "locked level moved")

endmodule

// ===== tb/dsg_checker.sv =====
`timescale 1ns / 100ps

module dsg_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dsg_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [dsg_pkg::CFG_W-1:0]     cfg_data_i,
  dsg_in_if                             in_if,
  dsg_out_if                            out_if,
  output int unsigned                   mismatches_o,
  output int unsigned                   pending_o
);
  import dsg_pkg::*;

  // governor registers as last written
  logic [TPUT_W-1:0]  thr_high;
  logic [TPUT_W-1:0]  thr_mid;
  logic [CONF_W-1:0]  conf_lo;
  logic [CONF_W-1:0]  conf_hi;
  logic [HYST_W-1:0]  hyst;
  logic [LOCK_W-1:0]  lock_us;

  // governor state
  logic               in_window;
  logic [LEVEL_W-1:0] cur_lvl;
  logic [LEVEL_W-1:0] nxt_lvl;
  logic               lock_held;
  logic [TIME_W-1:0]  win_end;
  logic [TIME_W-1:0]  last_switch;
  logic [FRAME_W-1:0] frames;

  res_t        status_q[$];
  int unsigned mismatch_cnt = 0;

  assign mismatches_o = mismatch_cnt;

  function automatic void gov_reset();
    thr_high    = HIGH_THR_RST;
    thr_mid     = MID_THR_RST;
    conf_lo     = CONF_LOW_RST;
    conf_hi     = CONF_HIGH_RST;
    hyst        = HYST_RST;
    lock_us     = LOCK_US_RST;
    in_window   = 1'b0;
    cur_lvl     = LVL_MAX;
    nxt_lvl     = LVL_MAX;
    lock_held   = 1'b0;
    win_end     = '0;
    last_switch = '0;
    frames      = '0;
  endfunction

  function automatic void gov_write(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_W-1:0] data);
    case (idx)
      CFG_HIGH_THR:  thr_high = data[TPUT_W-1:0];
      CFG_MID_THR:   thr_mid  = data[TPUT_W-1:0];
      CFG_CONF_LOW:  conf_lo  = data[CONF_W-1:0];
      CFG_CONF_HIGH: conf_hi  = data[CONF_W-1:0];
      CFG_HYST:      hyst     = data[HYST_W-1:0];
      CFG_LOCK_US:   lock_us  = data[LOCK_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic logic [LEVEL_W-1:0] tput_level(input logic [TPUT_W-1:0] mbps);
    if (mbps > thr_high) return LVL_MAX;
    if (mbps > thr_mid) return LVL_BAL;
    return LVL_EFF;
  endfunction

  function automatic res_t gov_step(input logic [CMD_W-1:0]   cmd,
                                    input logic [TIME_W-1:0]  now,
                                    input logic [TPUT_W-1:0]  mbps,
                                    input logic [CONF_W-1:0]  conf,
                                    input logic [LEVEL_W-1:0] tgt);
    logic [LEVEL_W-1:0] old_lvl;
    logic [LEVEL_W-1:0] target;
    logic [TIME_W-1:0]  guard;
    res_t               r;
    old_lvl = cur_lvl;
    case (cmd)
      CMD_TIMED: begin
        if (in_window) begin
          // close the window once its end is reached
          if (now >= win_end) begin
            cur_lvl     = nxt_lvl;
            in_window   = 1'b0;
            last_switch = win_end;
            frames      = '0;
          end
        end else if (!lock_held) begin
          target = tput_level(mbps);
          guard  = 64'(hyst) * 64'(FRAME_PERIOD_US);
          if (target != cur_lvl && frames > 16'(hyst) && (now - last_switch) > guard) begin
            in_window = 1'b1;
            win_end   = now + 64'(lock_us);
            nxt_lvl   = target;
          end
        end
      end
      CMD_CONF: begin
        if (conf >= conf_lo && !lock_held) begin
          target = (conf >= conf_hi) ? tput_level(mbps) : LVL_BAL;
          if (target != cur_lvl && frames > 16'(hyst)) begin
            cur_lvl = target;
            frames  = '0;
          end
        end
      end
      CMD_STALL: begin
        in_window = 1'b0;
        cur_lvl   = LVL_MAX;
        frames    = '0;
      end
      CMD_FORCE: begin
        lock_held = 1'b1;
        cur_lvl   = (tgt > LVL_EFF) ? LVL_EFF : tgt;
        frames    = '0;
      end
      CMD_RELEASE: lock_held = 1'b0;
      CMD_FRAME: begin
        if (frames != '1) frames = frames + 16'd1;
      end
      default: ;
    endcase
    r.level         = cur_lvl;
    r.in_transition = in_window;
    r.pending_level = nxt_lvl;
    r.locked        = lock_held;
    r.changed       = (cur_lvl != old_lvl);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    res_t got;
    res_t want;
    if (!rst_ni) begin
      gov_reset();
      status_q.delete();
      pending_o <= 0;
    end else begin
      // retire the returned word before queueing the new one
      if (out_if.valid && out_if.ready) begin
        got.level         = out_if.level;
        got.in_transition = out_if.in_transition;
        got.pending_level = out_if.pending_level;
        got.locked        = out_if.locked;
        got.changed       = out_if.changed;
        if (status_q.size() == 0) begin
          if (mismatch_cnt < 10)
            $display("%0t: status word with nothing outstanding:", $realtime,
                     " lvl=%0d tr=%0b pend=%0d lk=%0b chg=%0b", got.level,
                     got.in_transition, got.pending_level, got.locked, got.changed);
          mismatch_cnt++;
        end else begin
          want = status_q.pop_front();
          if (got.level !== want.level || got.in_transition !== want.in_transition ||
              got.pending_level !== want.pending_level || got.locked !== want.locked ||
              got.changed !== want.changed) begin
            if (mismatch_cnt < 10)
              $display("%0t: status mismatch:", $realtime,
                       " exp lvl=%0d tr=%0b pend=%0d lk=%0b chg=%0b", want.level,
                       want.in_transition, want.pending_level, want.locked, want.changed,
                       ", got lvl=%0d tr=%0b pend=%0d lk=%0b chg=%0b", got.level,
                       got.in_transition, got.pending_level, got.locked, got.changed);
            mismatch_cnt++;
          end
        end
      end
      if (in_if.valid && in_if.ready)
        status_q.push_back(gov_step(in_if.command, in_if.time_us, in_if.throughput,
                                    in_if.confidence_q8, in_if.target_level));
      if (cfg_we_i) gov_write(cfg_idx_i, cfg_data_i);
      pending_o <= status_q.size();
    end
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import dsg_pkg::*;

  localparam logic [CMD_W-1:0] CMD_SPARE6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE7 = 3'd7;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned PHASE_WORDS = 140;

  localparam int unsigned SRC_MODE [4] = '{0, 57, 0, 24};
  localparam int unsigned SNK_MODE [4] = '{0, 0, 57, 24};

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_data;

  int unsigned failures;
  int unsigned pending_words;
  int unsigned idle_cycles;
  int unsigned src_idle_pct = 0;
  int unsigned snk_stall_pct = 0;
  logic        long_hold = 1'b0;

  // register values in force, used to aim the stimulus
  logic [TPUT_W-1:0] thr_hi_cfg  = HIGH_THR_RST;
  logic [TPUT_W-1:0] thr_mid_cfg = MID_THR_RST;
  logic [CONF_W-1:0] conf_lo_cfg = CONF_LOW_RST;
  logic [CONF_W-1:0] conf_hi_cfg = CONF_HIGH_RST;
  logic [HYST_W-1:0] hyst_cfg    = HYST_RST;
  logic [LOCK_W-1:0] lock_cfg    = LOCK_US_RST;
  logic [TIME_W-1:0] now_us      = '0;

  dsg_in_if  word_in ();
  dsg_out_if word_out ();

  dvfs_state_governor dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_if      (word_in),
    .out_if     (word_out)
  );

  dsg_checker gov_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .in_if        (word_in),
    .out_if       (word_out),
    .mismatches_o (failures),
    .pending_o    (pending_words)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // receiver: random stalls, or one long hold-off when asked
  initial begin
    word_out.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        long_hold = 1'b0;
        word_out.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        word_out.ready <= (snk_stall_pct == 0) || ($urandom_range(99) >= snk_stall_pct);
      end
    end
  end

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((word_in.valid && word_in.ready) || (word_out.valid && word_out.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_word(input logic [CMD_W-1:0]   cmd,
                           input logic [TIME_W-1:0]  t,
                           input logic [TPUT_W-1:0]  tp,
                           input logic [CONF_W-1:0]  cf,
                           input logic [LEVEL_W-1:0] tg);
    while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      word_in.valid <= 1'b0;
      @(negedge clk);
    end
    word_in.valid         <= 1'b1;
    word_in.command       <= cmd;
    word_in.time_us       <= t;
    word_in.throughput    <= tp;
    word_in.confidence_q8 <= cf;
    word_in.target_level  <= tg;
    @(posedge clk);
    while (!word_in.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_word(CMD_FRAME, {$urandom, $urandom}, $urandom, 9'($urandom), 2'($urandom));
  endtask

  function automatic logic [TPUT_W-1:0] pick_tput();
    case ($urandom_range(6))
      0: return '0;
      1: return '1;
      2: return thr_mid_cfg;
      3: return thr_mid_cfg + 32'd1;
      4: return thr_hi_cfg;
      5: return thr_hi_cfg + 32'd1;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random_word();
    int unsigned       pick;
    int unsigned       span;
    logic [CMD_W-1:0]  cmd;
    logic [TIME_W-1:0] t;
    logic [TPUT_W-1:0] tp;
    logic [CONF_W-1:0] cf;
    logic [LEVEL_W-1:0] tg;
    pick = $urandom_range(99);
    span = 2 * 32'(lock_cfg) + 2;
    // unused fields carry noise
    t  = {$urandom, $urandom};
    tp = $urandom;
    cf = 9'($urandom);
    tg = 2'($urandom);
    if (pick < 30) begin
      cmd = CMD_FRAME;
    end else if (pick < 60) begin
      cmd = CMD_TIMED;
      // advance the clock: inside the window, past the guard, or jump about
      case ($urandom_range(9))
        0, 1, 2, 3: now_us = now_us + 64'($urandom_range(0, span));
        4, 5, 6, 7: now_us = now_us + 64'(hyst_cfg) * 64'(FRAME_PERIOD_US)
                             + 64'($urandom_range(0, 20000));
        8: now_us = {$urandom, $urandom};
        default: now_us = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, span));
      endcase
      t  = now_us;
      tp = pick_tput();
    end else if (pick < 80) begin
      cmd = CMD_CONF;
      tp  = pick_tput();
      case ($urandom_range(7))
        0: cf = '0;
        1: cf = 9'd256;
        2: cf = conf_lo_cfg - 9'd1;
        3: cf = conf_lo_cfg;
        4: cf = conf_hi_cfg - 9'd1;
        5: cf = conf_hi_cfg;
        6: cf = 9'($urandom_range(0, 256));
        default: cf = 9'($urandom);
      endcase
    end else if (pick < 85) begin
      cmd = CMD_STALL;
    end else if (pick < 89) begin
      cmd = CMD_FORCE;
    end else if (pick < 97) begin
      cmd = CMD_RELEASE;
    end else begin
      cmd = $urandom_range(1) ? CMD_SPARE6 : CMD_SPARE7;
    end
    send_word(cmd, t, tp, cf, tg);
  endtask

  task automatic drain();
    word_in.valid <= 1'b0;
    while (pending_words != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic put_reg(input cfg_idx_e idx, input logic [CFG_W-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(negedge clk);
  endtask

  task automatic configure(input logic [TPUT_W-1:0] hi,
                           input logic [TPUT_W-1:0] mid,
                           input logic [CONF_W-1:0] clo,
                           input logic [CONF_W-1:0] chi,
                           input logic [HYST_W-1:0] hys,
                           input logic [LOCK_W-1:0] lck);
    drain();
    put_reg(CFG_HIGH_THR, hi);
    put_reg(CFG_MID_THR, mid);
    put_reg(CFG_CONF_LOW, 32'(clo));
    put_reg(CFG_CONF_HIGH, 32'(chi));
    put_reg(CFG_HYST, 32'(hys));
    put_reg(CFG_LOCK_US, 32'(lck));
    cfg_we <= 1'b0;
    thr_hi_cfg  = hi;
    thr_mid_cfg = mid;
    conf_lo_cfg = clo;
    conf_hi_cfg = chi;
    hyst_cfg    = hys;
    lock_cfg    = lck;
  endtask

  task automatic run_phase(input int n, input int unsigned src_pct,
                           input int unsigned snk_pct, input int hold_at);
    src_idle_pct  = src_pct;
    snk_stall_pct = snk_pct;
    for (int i = 0; i < n; i++) begin
      if (i == hold_at) long_hold = 1'b1;
      send_random_word();
    end
  endtask

  initial begin
    logic [TPUT_W-1:0] hi;
    logic [TPUT_W-1:0] mid;
    logic [CONF_W-1:0] clo;
    logic [CONF_W-1:0] chi;
    word_in.valid         = 1'b0;
    word_in.command       = CMD_TIMED;
    word_in.time_us       = '0;
    word_in.throughput    = '0;
    word_in.confidence_q8 = '0;
    word_in.target_level  = LVL_MAX;
    cfg_we   = 1'b0;
    cfg_idx  = CFG_HIGH_THR;
    cfg_data = '0;
    rst_n    = 1'b0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed pass at reset settings
    send_ticks(4);
    send_word(CMD_TIMED, 64'd60000, 32'd0, 9'd0, LVL_MAX);
    // confidence update while the window is open
    send_word(CMD_CONF, 64'd0, 32'd30000, 9'd256, LVL_MAX);
    send_word(CMD_TIMED, 64'd60499, 32'd0, 9'd0, LVL_MAX);
    send_word(CMD_TIMED, 64'd60500, 32'd0, 9'd0, LVL_MAX);
    send_word(CMD_CONF, 64'd0, 32'hFFFF_FFFF, 9'd89, LVL_MAX);
    send_ticks(4);
    // confidence above 256 is compared as given
    send_word(CMD_CONF, 64'd0, 32'hFFFF_FFFF, 9'd300, LVL_MAX);
    // forced level 3 maps to efficient
    send_word(CMD_FORCE, 64'd0, 32'd0, 9'd0, 2'd3);
    send_word(CMD_CONF, 64'd0, 32'hFFFF_FFFF, 9'd256, LVL_MAX);
    send_word(CMD_TIMED, 64'd1000000, 32'hFFFF_FFFF, 9'd0, LVL_MAX);
    send_word(CMD_RELEASE, 64'd0, 32'd0, 9'd0, LVL_MAX);
    send_word(CMD_SPARE6, '1, '1, '1, 2'd3);
    send_word(CMD_SPARE7, '1, '1, '1, 2'd3);
    send_word(CMD_STALL, 64'd0, 32'd0, 9'd0, LVL_MAX);
    send_word(CMD_FORCE, 64'd0, 32'd0, 9'd0, LVL_BAL);
    send_word(CMD_RELEASE, 64'd0, 32'd0, 9'd0, LVL_MAX);
    now_us = 64'd2000000;

    run_phase(PHASE_WORDS, 0, 0, 50);

    configure('0, '0, '0, 9'd256, '0, '0);
    run_phase(PHASE_WORDS, 57, 0, -1);

    configure('1, '1, 9'd256, '0, 8'd255, '1);
    run_phase(PHASE_WORDS, 0, 57, -1);

    configure(32'd50000, 32'd10000, 9'd100, 9'd200, 8'd1, 24'd1000);
    run_phase(PHASE_WORDS, 24, 24, -1);

    for (int p = 0; p < 4; p++) begin
      hi  = $urandom_range(1000, 90000);
      mid = $urandom_range(0, hi);
      clo = 9'($urandom_range(0, 200));
      chi = 9'($urandom_range(clo, 256));
      configure(hi, mid, clo, chi, 8'($urandom_range(0, 6)), 24'($urandom_range(0, 20000)));
      run_phase(PHASE_WORDS, SRC_MODE[p], SNK_MODE[p], -1);
    end

    drain();
    if (failures == 0 && pending_words == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
